// ===== rtl/cdft_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdft_pkg
// shared constants, angle table and register indexes for the fingertip test
// ----------------------------------------------------------------------------
package cdft_pkg;

    localparam int COORD_BITS      = 12;
    localparam int ANGLE_FRAC_BITS = 6;
    localparam int CORDIC_FRAC     = 16;
    localparam int CORDIC_STEPS    = 19;
    localparam int HALF_TURN       = 180;
    localparam int LIMIT_BITS      = 9;
    localparam int PCT_BITS        = 8;
    localparam int CFG_DATA_BITS   = 9;
    localparam int CFG_IDX_BITS    = 3;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_MIN       = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_ANGLE_MAX       = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_INNER_ANGLE_MIN = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_INNER_ANGLE_MAX = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH_MIN_PCT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_LENGTH_MAX_PCT  = 3'd5;

    // cordic operands: inner vector components reach about 2^25, scaled by 2^16
    localparam int VEC_BITS = 2 * COORD_BITS + 3;
    localparam int CW       = VEC_BITS + CORDIC_FRAC + 2;
    localparam int ZW       = 9 + CORDIC_FRAC + 2;
    localparam int AW       = ZW - (CORDIC_FRAC - ANGLE_FRAC_BITS) + 1;

    typedef logic signed [CW-1:0]       cw_t;
    typedef logic signed [ZW-1:0]       zw_t;
    typedef logic signed [AW-1:0]       ang_t;
    typedef logic signed [VEC_BITS-1:0] vec_t;

    // degrees * 2^16, rounded
    function automatic zw_t atan_deg(input int i);
        case (i)
            0:  atan_deg = ZW'(2949120);
            1:  atan_deg = ZW'(1740967);
            2:  atan_deg = ZW'(919879);
            3:  atan_deg = ZW'(466945);
            4:  atan_deg = ZW'(234379);
            5:  atan_deg = ZW'(117304);
            6:  atan_deg = ZW'(58666);
            7:  atan_deg = ZW'(29335);
            8:  atan_deg = ZW'(14668);
            9:  atan_deg = ZW'(7334);
            10: atan_deg = ZW'(3667);
            11: atan_deg = ZW'(1833);
            12: atan_deg = ZW'(917);
            13: atan_deg = ZW'(458);
            14: atan_deg = ZW'(229);
            15: atan_deg = ZW'(115);
            16: atan_deg = ZW'(57);
            17: atan_deg = ZW'(29);
            18: atan_deg = ZW'(14);
            default: atan_deg = '0;
        endcase
    endfunction

    // per-lane cordic state
    typedef struct packed {
        cw_t  x;
        cw_t  y;
        zw_t  z;
        logic spec;   // angle fixed without iteration
        ang_t fixed;
    } cord_t;

endpackage

// ===== rtl/cdft_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdft_cordic
// pipelined vectoring cordic: angle of (x, y) in 1/64 degree, one step a stage
// ----------------------------------------------------------------------------
module cdft_cordic
    import cdft_pkg::*;
(
    input  logic aclk,
    input  logic en,
    input  vec_t vx,
    input  vec_t vy,
    output ang_t angle
);

    localparam int SH = CORDIC_FRAC - ANGLE_FRAC_BITS;

    cord_t st_reg [CORDIC_STEPS+1];
    cord_t st_next [CORDIC_STEPS+1];
    ang_t  angle_reg;

    // pre-rotation and special cases
    always_comb begin
        cw_t xe;
        cw_t ye;
        xe = CW'(vx);
        ye = CW'(vy);
        st_next[0] = '0;
        if (vy == '0) begin
            st_next[0].spec  = 1'b1;
            st_next[0].fixed = (vx < 0) ? AW'(HALF_TURN << ANGLE_FRAC_BITS) : '0;
        end else if (vx == '0) begin
            st_next[0].spec  = 1'b1;
            st_next[0].fixed = (vy > 0) ? AW'(90 << ANGLE_FRAC_BITS)
                                        : -AW'(90 << ANGLE_FRAC_BITS);
        end else if (vx < 0) begin
            if (vy > 0) begin
                st_next[0].x = ye <<< CORDIC_FRAC;
                st_next[0].y = (-xe) <<< CORDIC_FRAC;
                st_next[0].z = ZW'(90 << CORDIC_FRAC);
            end else begin
                st_next[0].x = (-ye) <<< CORDIC_FRAC;
                st_next[0].y = xe <<< CORDIC_FRAC;
                st_next[0].z = -ZW'(90 << CORDIC_FRAC);
            end
        end else begin
            st_next[0].x = xe <<< CORDIC_FRAC;
            st_next[0].y = ye <<< CORDIC_FRAC;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        always_comb begin
            st_next[i+1] = st_reg[i];
            if (st_reg[i].y > 0) begin
                st_next[i+1].x = st_reg[i].x + (st_reg[i].y >>> i);
                st_next[i+1].y = st_reg[i].y - (st_reg[i].x >>> i);
                st_next[i+1].z = st_reg[i].z + atan_deg(i);
            end else begin
                st_next[i+1].x = st_reg[i].x - (st_reg[i].y >>> i);
                st_next[i+1].y = st_reg[i].y + (st_reg[i].x >>> i);
                st_next[i+1].z = st_reg[i].z - atan_deg(i);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i <= CORDIC_STEPS; i++) begin
                st_reg[i] <= st_next[i];
            end
            angle_reg <= st_reg[CORDIC_STEPS].spec ? st_reg[CORDIC_STEPS].fixed
                       : AW'((st_reg[CORDIC_STEPS].z + ZW'((1 << SH) >> 1)) >>> SH);
        end
    end

    assign angle = angle_reg;

endmodule

// ===== rtl/convexity_defect_finger_test_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convexity_defect_finger_test_core
// classifies a convexity defect start point as a fingertip
// ----------------------------------------------------------------------------
// throughput: one defect per cycle while not stalled; set by the 19-step cordic pipelines
// the whole pipe advances together; it stalls only when the last stage holds
// an untaken result and the output is not ready
// reset: synchronous active-low aresetn clears all valid bits and loads the
// register defaults; payload registers are not reset
// ----------------------------------------------------------------------------
module convexity_defect_finger_test_core
    import cdft_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data,
    // input beats
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [COORD_BITS-1:0]    s_tip_x,
    input  logic [COORD_BITS-1:0]    s_tip_y,
    input  logic [COORD_BITS-1:0]    s_end_x,
    input  logic [COORD_BITS-1:0]    s_end_y,
    input  logic [COORD_BITS-1:0]    s_depth_x,
    input  logic [COORD_BITS-1:0]    s_depth_y,
    input  logic [COORD_BITS-1:0]    s_centre_x,
    input  logic [COORD_BITS-1:0]    s_centre_y,
    input  logic [COORD_BITS-1:0]    s_box_height,
    // result beats
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_is_finger,
    output logic [COORD_BITS-1:0]    m_finger_x,
    output logic [COORD_BITS-1:0]    m_finger_y
);

    // front stages before the cordic: s1 deltas, s2 products, s3 cross/dot
    localparam int CORD_LAT = CORDIC_STEPS + 2;
    localparam int DEPTH    = 3 + CORD_LAT + 1;
    localparam int CB       = COORD_BITS + 1;
    localparam int D2B      = 2 * COORD_BITS + 1;
    localparam int LB       = D2B + 14;
    localparam int HB       = COORD_BITS + PCT_BITS;

    typedef logic signed [CB-1:0] dlt_t;

    // configuration registers
    logic [LIMIT_BITS-1:0] angle_min_reg, angle_max_reg;
    logic [LIMIT_BITS-1:0] inner_min_reg, inner_max_reg;
    logic [PCT_BITS-1:0]   len_min_reg, len_max_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_min_reg <= LIMIT_BITS'(0);
            angle_max_reg <= LIMIT_BITS'(360);
            inner_min_reg <= LIMIT_BITS'(180);
            inner_max_reg <= LIMIT_BITS'(360);
            len_min_reg   <= PCT_BITS'(0);
            len_max_reg   <= PCT_BITS'(100);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ANGLE_MIN:       angle_min_reg <= cfg_data;
                REG_ANGLE_MAX:       angle_max_reg <= cfg_data;
                REG_INNER_ANGLE_MIN: inner_min_reg <= cfg_data;
                REG_INNER_ANGLE_MAX: inner_max_reg <= cfg_data;
                REG_LENGTH_MIN_PCT:  len_min_reg   <= cfg_data[PCT_BITS-1:0];
                REG_LENGTH_MAX_PCT:  len_max_reg   <= cfg_data[PCT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // global advance: a bubble in the last stage or a taken result frees the pipe
    logic [DEPTH-1:0] vld_reg;
    logic             adv;

    assign m_valid = vld_reg[DEPTH-1];
    assign adv     = !vld_reg[DEPTH-1] || m_ready;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[DEPTH-2:0], s_valid};
        end
    end

    // stage 1: differences
    dlt_t dir_x_reg, dir_y_reg, tdx_reg, tdy_reg, edx_reg, edy_reg;
    dlt_t etx_reg, ety_reg;
    logic [COORD_BITS-1:0] h1_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            dir_x_reg <= dlt_t'({1'b0, s_centre_x}) - dlt_t'({1'b0, s_tip_x});
            dir_y_reg <= dlt_t'({1'b0, s_centre_y}) - dlt_t'({1'b0, s_tip_y});
            tdx_reg   <= dlt_t'({1'b0, s_tip_x}) - dlt_t'({1'b0, s_depth_x});
            tdy_reg   <= dlt_t'({1'b0, s_tip_y}) - dlt_t'({1'b0, s_depth_y});
            edx_reg   <= dlt_t'({1'b0, s_end_x}) - dlt_t'({1'b0, s_depth_x});
            edy_reg   <= dlt_t'({1'b0, s_end_y}) - dlt_t'({1'b0, s_depth_y});
            etx_reg   <= dlt_t'({1'b0, s_end_x}) - dlt_t'({1'b0, s_tip_x});
            ety_reg   <= dlt_t'({1'b0, s_end_y}) - dlt_t'({1'b0, s_tip_y});
            h1_reg    <= s_box_height;
        end
    end

    // stage 2: squared distances, height products
    logic [D2B-1:0] d1_reg, d2_reg;
    logic [HB-1:0]  lo_h_reg, hi_h_reg;
    dlt_t dir2_x_reg, dir2_y_reg, tdx2_reg, tdy2_reg, edx2_reg, edy2_reg;
    dlt_t etx2_reg, ety2_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            d1_reg     <= D2B'(tdx_reg * tdx_reg) + D2B'(tdy_reg * tdy_reg);
            d2_reg     <= D2B'(edx_reg * edx_reg) + D2B'(edy_reg * edy_reg);
            lo_h_reg   <= HB'(len_min_reg) * HB'(h1_reg);
            hi_h_reg   <= HB'(len_max_reg) * HB'(h1_reg);
            dir2_x_reg <= dir_x_reg;
            dir2_y_reg <= dir_y_reg;
            tdx2_reg   <= tdx_reg;
            tdy2_reg   <= tdy_reg;
            edx2_reg   <= edx_reg;
            edy2_reg   <= edy_reg;
            etx2_reg   <= etx_reg;
            ety2_reg   <= ety_reg;
        end
    end

    // stage 3: pick far point, cross and dot, length products
    // with a = tip: p = end - tip, q = depth - tip; with a = end: p = tip - end
    logic [LB-1:0]  l_lhs_reg;
    logic [2*HB-1:0] lo_sq_reg, hi_sq_reg;
    vec_t cr_reg, dot_reg, dir3_x_reg, dir3_y_reg;
    logic zero_reg;

    dlt_t p1_c, p2_c, q1_c, q2_c;
    vec_t cr_c;
    always_comb begin
        if (d1_reg < d2_reg) begin
            p1_c = tdx2_reg - edx2_reg;
            p2_c = tdy2_reg - edy2_reg;
            q1_c = -edx2_reg;
            q2_c = -edy2_reg;
        end else begin
            p1_c = etx2_reg;
            p2_c = ety2_reg;
            q1_c = -tdx2_reg;
            q2_c = -tdy2_reg;
        end
        cr_c = VEC_BITS'(p1_c * q2_c) - VEC_BITS'(p2_c * q1_c);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cr_reg     <= (cr_c < 0) ? -cr_c : cr_c;
            dot_reg    <= VEC_BITS'(p1_c * q1_c) + VEC_BITS'(p2_c * q2_c);
            zero_reg   <= (p1_c == '0 && p2_c == '0) || (q1_c == '0 && q2_c == '0);
            l_lhs_reg  <= LB'(d1_reg) * LB'(10000);
            lo_sq_reg  <= (2*HB)'(lo_h_reg) * (2*HB)'(lo_h_reg);
            hi_sq_reg  <= (2*HB)'(hi_h_reg) * (2*HB)'(hi_h_reg);
            dir3_x_reg <= VEC_BITS'(dir2_x_reg);
            dir3_y_reg <= VEC_BITS'(dir2_y_reg);
        end
    end

    // cordic pipelines for direction and inner angle
    ang_t dir_ang, inner_ang;

    cdft_cordic u_dir (
        .aclk  (aclk),
        .en    (adv),
        .vx    (dir3_x_reg),
        .vy    (dir3_y_reg),
        .angle (dir_ang)
    );

    cdft_cordic u_inner (
        .aclk  (aclk),
        .en    (adv),
        .vx    (dot_reg),
        .vy    (cr_reg),
        .angle (inner_ang)
    );

    // side delay line: length verdict, zero flag and tip coordinates
    logic                  len_ok_c;
    logic                  len_d_reg  [CORD_LAT];
    logic                  zero_d_reg [CORD_LAT];
    logic [COORD_BITS-1:0] tx_d_reg   [DEPTH-1];
    logic [COORD_BITS-1:0] ty_d_reg   [DEPTH-1];

    assign len_ok_c = ((2*HB+1)'(l_lhs_reg) > (2*HB+1)'(lo_sq_reg))
                   && ((2*HB+1)'(l_lhs_reg) < (2*HB+1)'(hi_sq_reg));

    always_ff @(posedge aclk) begin
        if (adv) begin
            len_d_reg[0]  <= len_ok_c;
            zero_d_reg[0] <= zero_reg;
            for (int i = 1; i < CORD_LAT; i++) begin
                len_d_reg[i]  <= len_d_reg[i-1];
                zero_d_reg[i] <= zero_d_reg[i-1];
            end
            tx_d_reg[0] <= s_tip_x;
            ty_d_reg[0] <= s_tip_y;
            for (int i = 1; i < DEPTH-1; i++) begin
                tx_d_reg[i] <= tx_d_reg[i-1];
                ty_d_reg[i] <= ty_d_reg[i-1];
            end
        end
    end

    // final stage: limit compares, limits shifted down by a half turn
    localparam int LW = LIMIT_BITS + ANGLE_FRAC_BITS + 2;
    typedef logic signed [LW-1:0] lim_t;

    function automatic lim_t to_lim(input logic [LIMIT_BITS-1:0] deg);
        to_lim = (lim_t'(deg) - lim_t'(HALF_TURN)) <<< ANGLE_FRAC_BITS;
    endfunction

    logic dir_ok_c, inner_ok_c;
    assign dir_ok_c   = (LW'(dir_ang) > to_lim(angle_min_reg))
                     && (LW'(dir_ang) < to_lim(angle_max_reg));
    assign inner_ok_c = !zero_d_reg[CORD_LAT-1]
                     && (LW'(inner_ang) > to_lim(inner_min_reg))
                     && (LW'(inner_ang) < to_lim(inner_max_reg));

    logic                  is_finger_reg;
    logic [COORD_BITS-1:0] fx_reg, fy_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            is_finger_reg <= dir_ok_c && inner_ok_c && len_d_reg[CORD_LAT-1];
            fx_reg        <= tx_d_reg[DEPTH-2];
            fy_reg        <= ty_d_reg[DEPTH-2];
        end
    end

    assign m_is_finger = is_finger_reg;
    assign m_finger_x  = fx_reg;
    assign m_finger_y  = fy_reg;

endmodule

// ===== rtl/cdft_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdft_checker
// port-level checks on the fingertip test core
// ----------------------------------------------------------------------------
module cdft_checker
    import cdft_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic                  m_is_finger,
    input logic [COORD_BITS-1:0] m_finger_x
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_finger) && $stable(m_finger_x))
        else $error("result changed while stalled");

    // input is open whenever the output is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked with free output");

    // input stalls only behind a stalled result
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without cause");

    // no result right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result after reset");

endmodule

bind convexity_defect_finger_test_core cdft_checker u_cdft_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_is_finger (m_is_finger),
    .m_finger_x  (m_finger_x)
);
